@@ hdl/wfd_pkg.sv @@
package wfd_pkg;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] TAG_PCM = 16'h0001;
  localparam logic [15:0] TAG_MP3 = 16'h0055;
  localparam logic [15:0] TAG_FLT = 16'h0003;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ERR_NOT_RIFF   = 4'd0;
  localparam logic [3:0] ERR_NOT_WAVE   = 4'd1;
  localparam logic [3:0] ERR_MP3        = 4'd2;
  localparam logic [3:0] ERR_TAG        = 4'd3;
  localparam logic [3:0] ERR_DEPTH      = 4'd4;
  localparam logic [3:0] ERR_DATA_FIRST = 4'd5;
  localparam logic [3:0] ERR_NO_DATA    = 4'd6;
  localparam logic [3:0] ERR_ZERO       = 4'd7;
  localparam logic [3:0] ERR_SHORT_FMT  = 4'd8;

  localparam int DIV_W     = 42;
  localparam int DVS_W     = 32;
  localparam int DIV_STEPS = DIV_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic [41:0] length_ms;
    logic [31:0] total_frames;
    logic        float_source;
    logic [5:0]  sample_bits;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [31:0] frame_position;
    logic [15:0] sample;
  } res_t;

endpackage

@@ hdl/wfd_div.sv @@
module wfd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  wfd_pkg::div_req_t          req,
  output logic                       done,
  output logic [wfd_pkg::DIV_W-1:0]  quotient
);

  logic                       busy;
  logic [wfd_pkg::DCNT_W-1:0] cnt;
  logic [wfd_pkg::DVS_W-1:0]  rem;
  logic [wfd_pkg::DVS_W-1:0]  dvs;
  logic [wfd_pkg::DIV_W-1:0]  quo;
  logic [wfd_pkg::DVS_W:0]    trial;
  logic                       ge;
  logic [wfd_pkg::DVS_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, quo[wfd_pkg::DIV_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? wfd_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[wfd_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[wfd_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == wfd_pkg::DCNT_W'(wfd_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ hdl/wfd_fcv.sv @@
module wfd_fcv (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] word,
  output logic        out_valid,
  output logic [15:0] sample
);

  logic        v1;
  logic        sgn1;
  logic        nan1;
  logic        big1;
  logic        tiny1;
  logic [7:0]  exp1;
  logic [38:0] prod1;

  logic        lead;
  logic [23:0] keep;
  logic        grd;
  logic        sticky;
  logic [24:0] rnd;
  logic [7:0]  rs;
  logic [24:0] mag;
  logic [15:0] conv;

  // stage 1: classify and scale the significand by 32767
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    sgn1  <= word[31];
    exp1  <= word[30:23];
    nan1  <= (word[30:23] == 8'hff) && (word[22:0] != 23'd0);
    big1  <= word[30:23] >= 8'd127;
    tiny1 <= word[30:23] < 8'd100;
    prod1 <= 39'({1'b1, word[22:0]}) * 39'd32767;
  end

  // stage 2: round to 24 bits, nearest even, then truncate to integer; NaN and tiny give 0, big saturates
  always_comb begin
    lead   = prod1[38];
    keep   = lead ? prod1[38:15] : prod1[37:14];
    grd    = lead ? prod1[14] : prod1[13];
    sticky = lead ? (|prod1[13:0]) : (|prod1[12:0]);
    rnd    = {1'b0, keep} + 25'(grd & (sticky | keep[0]));
    rs     = 8'd150 - exp1 - (lead ? 8'd15 : 8'd14);
    mag    = rnd >> rs[5:0];
    if (nan1 || tiny1) begin
      conv = 16'd0;
    end else if (big1) begin
      conv = sgn1 ? -16'sd32767 : 16'sd32767;
    end else begin
      conv = sgn1 ? 16'(-mag[15:0]) : mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    sample <= conv;
  end

endmodule

@@ hdl/wave_file_to_pcm16_decoder.sv @@
// channel   dir  tdata                                  tuser   tlast
// s_*       in   data_byte                              -       end_of_file
// m_*       out  sample .. error_code (181 bits used)   kind    -
//
// a byte that yields no result leaves s_tready high; an integer sample or an error goes through ST_EMIT
// a float sample first goes through the two-stage converter in ST_FLT
// the data chunk header needs two 42-step passes of the shared divider, for total_frames and length_ms
// s_tready is low while an item is at work; a finished result waits in the output register
// rst is synchronous and clears the parser to expect a new file
module wave_file_to_pcm16_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // end_of_file
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [183:0] m_tdata,   // sample, frame_position, channel_count, sample_rate,
                                  // sample_bits, float_source, total_frames, length_ms,
                                  // error_code
  output logic [1:0]   m_tuser    // kind
);

  typedef enum logic [13:0] {
    PH_RIFF  = 14'b00000000000001,
    PH_RSIZE = 14'b00000000000010,
    PH_WAVE  = 14'b00000000000100,
    PH_CID   = 14'b00000000001000,
    PH_CSIZE = 14'b00000000010000,
    PH_TAG   = 14'b00000000100000,
    PH_CHAN  = 14'b00000001000000,
    PH_RATE  = 14'b00000010000000,
    PH_GAP   = 14'b00000100000000,
    PH_BITS  = 14'b00001000000000,
    PH_SKIP  = 14'b00010000000000,
    PH_DATA  = 14'b00100000000000,
    PH_DONE  = 14'b01000000000000,
    PH_HALT  = 14'b10000000000000
  } phase_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV_FR  = 6'b000010,
    ST_MUL     = 6'b000100,
    ST_DIV_LEN = 6'b001000,
    ST_FLT     = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  state_t state;
  phase_t phase, phase_next;
  logic [2:0]  cnt, cnt_next;
  logic [31:0] shift, shift_next;
  logic [31:0] ckid, ckid_next;
  logic [32:0] skip, skip_next;
  logic [15:0] tag, tag_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] bits, bits_next;
  logic        found, found_next;
  logic [31:0] drem, drem_next;
  logic [15:0] cif, cif_next;
  logic [31:0] frames, frames_next;

  wfd_pkg::res_t res, res_next, out_res;
  logic        acc;
  logic        emit;
  logic        go_div;
  logic        go_flt;
  logic [31:0] gshift;
  logic [3:0]  cnt1;
  logic [3:0]  need;
  logic        gdone;
  logic [2:0]  bps;
  logic [32:0] skip_dec;

  wfd_pkg::div_req_t             div_req;
  logic                          div_done;
  logic [wfd_pkg::DIV_W-1:0]     div_q;
  logic                          flt_valid;
  logic [15:0]                   flt_sample;

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    phase_next    = phase;
    cnt_next      = cnt;
    shift_next    = shift;
    ckid_next     = ckid;
    skip_next     = skip;
    tag_next      = tag;
    chans_next    = chans;
    rate_next     = rate;
    bits_next     = bits;
    found_next    = found;
    drem_next     = drem;
    cif_next      = cif;
    frames_next   = frames;
    res_next      = '0;
    emit          = 1'b0;
    go_div        = 1'b0;
    go_flt        = 1'b0;
    skip_dec      = '0;

    bps    = bits[5:3];
    gshift = shift | (32'(s_tdata) << {cnt[1:0], 3'b000});
    cnt1   = {1'b0, cnt} + 4'd1;
    case (phase)
      PH_TAG, PH_CHAN, PH_BITS: need = 4'd2;
      PH_DATA:                  need = {1'b0, bps};
      default:                  need = 4'd4;
    endcase
    gdone = cnt1 >= need;

    if (gdone) begin
      cnt_next   = '0;
      shift_next = '0;
    end else begin
      cnt_next   = cnt1[2:0];
      shift_next = gshift;
    end

    case (phase)
      PH_RIFF: begin
        if (gdone) begin
          if (gshift != wfd_pkg::ID_RIFF) begin
            emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
            res_next.error_code = wfd_pkg::ERR_NOT_RIFF; phase_next = PH_HALT;
          end else begin
            phase_next = PH_RSIZE;
          end
        end
      end
      PH_RSIZE: begin
        if (gdone) phase_next = PH_WAVE;
      end
      PH_WAVE: begin
        if (gdone) begin
          if (gshift != wfd_pkg::ID_WAVE) begin
            emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
            res_next.error_code = wfd_pkg::ERR_NOT_WAVE; phase_next = PH_HALT;
          end else begin
            phase_next = PH_CID;
          end
        end
      end
      PH_CID: begin
        if (gdone) begin
          ckid_next  = gshift;
          phase_next = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        if (gdone) begin
          if (ckid == wfd_pkg::ID_FMT) begin
            if (gshift < 32'd16) begin
              emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
              res_next.error_code = wfd_pkg::ERR_SHORT_FMT; phase_next = PH_HALT;
            end else begin
              skip_next  = 33'(gshift - 32'd16) + 33'(gshift[0]);
              phase_next = PH_TAG;
            end
          end else if (ckid == wfd_pkg::ID_DATA) begin
            if (!found) begin
              emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
              res_next.error_code = wfd_pkg::ERR_DATA_FIRST; phase_next = PH_HALT;
            end else begin
              emit   = 1'b1;
              go_div = 1'b1;
              res_next.kind          = wfd_pkg::KIND_HEADER;
              res_next.channel_count = chans;
              res_next.sample_rate   = rate;
              res_next.sample_bits   = bits[5:0];
              res_next.float_source  = (tag == wfd_pkg::TAG_FLT);
              drem_next   = gshift;
              frames_next = '0;
              cif_next    = '0;
              phase_next  = (gshift == 32'd0) ? PH_DONE : PH_DATA;
            end
          end else begin
            skip_next  = 33'(gshift) + 33'(gshift[0]);
            phase_next = (gshift == 32'd0) ? PH_CID : PH_SKIP;
          end
        end
      end
      PH_TAG: begin
        if (gdone) begin
          tag_next = gshift[15:0];
          if (gshift[15:0] == wfd_pkg::TAG_MP3) begin
            emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
            res_next.error_code = wfd_pkg::ERR_MP3; phase_next = PH_HALT;
          end else if (gshift[15:0] != wfd_pkg::TAG_PCM && gshift[15:0] != wfd_pkg::TAG_FLT) begin
            emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
            res_next.error_code = wfd_pkg::ERR_TAG; phase_next = PH_HALT;
          end else begin
            phase_next = PH_CHAN;
          end
        end
      end
      PH_CHAN: begin
        if (gdone) begin
          chans_next = gshift[15:0];
          phase_next = PH_RATE;
        end
      end
      PH_RATE: begin
        if (gdone) begin
          rate_next  = gshift;
          phase_next = PH_GAP;
        end
      end
      PH_GAP: begin
        shift_next = shift;
        if (cnt1 >= 4'd6) begin
          cnt_next   = '0;
          phase_next = PH_BITS;
        end else begin
          cnt_next = cnt1[2:0];
        end
      end
      PH_BITS: begin
        if (gdone) begin
          bits_next = gshift[15:0];
          if ((tag == wfd_pkg::TAG_FLT) ? (gshift[15:0] != 16'd32) :
              (gshift[15:0] != 16'd8 && gshift[15:0] != 16'd16 &&
               gshift[15:0] != 16'd24)) begin
            emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
            res_next.error_code = wfd_pkg::ERR_DEPTH; phase_next = PH_HALT;
          end else if (chans == 16'd0 || rate == 32'd0) begin
            emit = 1'b1; res_next.kind = wfd_pkg::KIND_ERROR;
            res_next.error_code = wfd_pkg::ERR_ZERO; phase_next = PH_HALT;
          end else begin
            found_next = 1'b1;
            phase_next = (skip == 33'd0) ? PH_CID : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        shift_next = shift;
        cnt_next   = cnt;
        skip_dec   = (skip != 33'd0) ? skip - 33'd1 : skip;
        skip_next  = skip_dec;
        if (skip_dec == 33'd0) phase_next = PH_CID;
      end
      PH_DATA: begin
        drem_next = drem - 32'd1;
        if (drem_next == 32'd0) phase_next = PH_DONE;
        if (gdone) begin
          emit = 1'b1;
          if ({1'b0, cif} + 17'd1 >= {1'b0, chans}) begin
            cif_next    = '0;
            frames_next = frames + 32'd1;
          end else begin
            cif_next = cif + 16'd1;
          end
          res_next.kind           = wfd_pkg::KIND_SAMPLE;
          res_next.frame_position = frames_next;
          case (bits)
            16'd8:   res_next.sample = {~gshift[7], gshift[6:0], 8'h00};
            16'd16:  res_next.sample = gshift[15:0];
            16'd24:  res_next.sample = gshift[23:8];
            default: go_flt = 1'b1;
          endcase
        end
      end
      default: begin
        shift_next = shift;
        cnt_next   = cnt;
      end
    endcase

    // end of file before the data chunk header
    if (s_tlast && !emit && phase_next != PH_HALT && phase != PH_DATA &&
        phase != PH_DONE && phase != PH_HALT) begin
      emit = 1'b1;
      res_next.kind = wfd_pkg::KIND_ERROR;
      if (phase == PH_RIFF) begin
        res_next.error_code = wfd_pkg::ERR_NOT_RIFF;
      end else if (phase == PH_RSIZE || phase == PH_WAVE) begin
        res_next.error_code = wfd_pkg::ERR_NOT_WAVE;
      end else begin
        res_next.error_code = wfd_pkg::ERR_NO_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && s_tlast)) begin
      phase    <= PH_RIFF;
      cnt      <= '0;
      shift    <= '0;
      ckid     <= '0;
      skip     <= '0;
      tag      <= '0;
      chans    <= '0;
      rate     <= '0;
      bits     <= '0;
      found    <= 1'b0;
      drem     <= '0;
      cif      <= '0;
      frames   <= '0;
    end else if (acc) begin
      phase    <= phase_next;
      cnt      <= cnt_next;
      shift    <= shift_next;
      ckid     <= ckid_next;
      skip     <= skip_next;
      tag      <= tag_next;
      chans    <= chans_next;
      rate     <= rate_next;
      bits     <= bits_next;
      found    <= found_next;
      drem     <= drem_next;
      cif      <= cif_next;
      frames   <= frames_next;
    end
  end

  always_comb begin
    div_req.start = (acc && go_div) || (state == ST_MUL);
    if (state == ST_MUL) begin
      div_req.dividend = wfd_pkg::DIV_W'(res.total_frames) * wfd_pkg::DIV_W'(1000);
      div_req.divisor  = res.sample_rate;
    end else begin
      div_req.dividend = wfd_pkg::DIV_W'(gshift);
      div_req.divisor  = wfd_pkg::DVS_W'(chans) * wfd_pkg::DVS_W'(bps);
    end
  end

  wfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  wfd_fcv u_fcv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc && go_flt),
    .word      (gshift),
    .out_valid (flt_valid),
    .sample    (flt_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc && emit) begin
            res <= res_next;
            if (go_div) begin
              state <= ST_DIV_FR;
            end else if (go_flt) begin
              state <= ST_FLT;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_DIV_FR: begin
          if (div_done) begin
            res.total_frames <= div_q[31:0];
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV_LEN;
        end
        ST_DIV_LEN: begin
          if (div_done) begin
            res.length_ms <= div_q;
            state <= ST_EMIT;
          end
        end
        ST_FLT: begin
          if (flt_valid) begin
            res.sample <= flt_sample;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            out_res <= res;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {3'b000, out_res.error_code, out_res.length_ms, out_res.total_frames,
                    out_res.float_source, out_res.sample_bits, out_res.sample_rate,
                    out_res.channel_count, out_res.frame_position, out_res.sample};

endmodule

@@ hdl/wfd_chk.sv @@
module wfd_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [7:0]   s_tdata,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [183:0] m_tdata,
  input logic [1:0]   m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == wfd_pkg::KIND_SAMPLE || m_tuser == wfd_pkg::KIND_HEADER ||
                 m_tuser == wfd_pkg::KIND_ERROR)
    else $error("unknown result kind");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == wfd_pkg::KIND_ERROR |-> m_tdata[176:0] == 177'd0)
    else $error("error item carries payload");

  a_known_handshake: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_tready, m_tvalid}))
    else $error("handshake output unknown");

endmodule

bind wave_file_to_pcm16_decoder wfd_chk u_wfd_chk (.*);

@@ tb/sv/wave_file_to_pcm16_decoder_test.sv @@
`timescale 1ns / 100ps

module wave_file_to_pcm16_decoder_test;

  typedef enum logic [3:0] {
    P_RIFF, P_RSIZE, P_WAVE, P_CID, P_CSIZE, P_TAG, P_CHAN, P_RATE, P_GAP, P_BITS,
    P_SKIP, P_DATA, P_DONE, P_HALT
  } parse_e;

  typedef enum int {
    F_GOOD, F_TRUNC, F_CORRUPT, F_NOISE, F_NOT_RIFF, F_NOT_WAVE, F_MP3, F_BAD_TAG,
    F_BAD_DEPTH, F_ZERO_CH, F_ZERO_RATE, F_SHORT_FMT, F_DATA_FIRST, F_NO_DATA, F_HUGE,
    F_TWO_FMT, F_WIDE
  } file_e;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } byte_item_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [7:0]   s_tdata = 0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [183:0] m_tdata;
  logic [1:0]   m_tuser;

  wave_file_to_pcm16_decoder u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  byte_item_t     file_bytes[$];
  wfd_pkg::res_t  decoded_q[$];
  int           idle_pct = 0;
  int           stall_pct = 0;
  logic         in_fire = 0;
  int           quiet_cycles = 0;
  int           mismatches = 0;
  int           n_bytes = 0;
  int           n_samples = 0;
  int           n_headers = 0;
  int           n_errors = 0;

  // decoder state mirror
  parse_e       ph;
  int           gcnt;
  logic [31:0]  gshift;
  logic [31:0]  ckid;
  logic [63:0]  skip_left;
  logic [15:0]  tag_seen;
  logic [15:0]  chans;
  logic [31:0]  rate;
  logic [15:0]  bits;
  logic         fmt_ok;
  logic [31:0]  data_left;
  logic [15:0]  chan_idx;
  logic [31:0]  frames;

  task automatic clear_parser();
    ph = P_RIFF; gcnt = 0; gshift = 0; ckid = 0; skip_left = 0; tag_seen = 0;
    chans = 0; rate = 0; bits = 0; fmt_ok = 0; data_left = 0; chan_idx = 0; frames = 0;
  endtask

  function automatic logic gather(logic [7:0] b, int n);
    gshift = gshift | (32'(b) << (8 * (gcnt & 3)));
    gcnt++;
    if (gcnt >= n) begin
      gcnt = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [15:0] float_to_s16(logic [31:0] w);
    logic [7:0]  e;
    logic [63:0] p, q, rem, half, mag;
    int          ex, len, d;
    e = w[30:23];
    if (e == 8'hff && w[22:0] != 0) return 16'd0;
    if (e >= 8'd127) begin
      mag = 64'd32767;
    end else begin
      ex = (e == 0) ? 1 : int'(e);
      p = (e == 0) ? 64'(w[22:0]) : 64'({1'b1, w[22:0]});
      p = p * 64'd32767;
      len = 0;
      for (int i = 0; i < 64; i++) if (p[i]) len = i + 1;
      if (len > 24) begin
        d = len - 24;
        q = p >> d;
        rem = p & ((64'd1 << d) - 1);
        half = 64'd1 << (d - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        p = q << d;
      end
      mag = p >> (150 - ex);
    end
    return w[31] ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic logic [15:0] to_pcm16(logic [31:0] w);
    case (bits)
      16'd8:   return {w[7:0] ^ 8'h80, 8'h00};
      16'd16:  return w[15:0];
      16'd24:  return w[23:8];
      default: return float_to_s16(w);
    endcase
  endfunction

  task automatic flag_error(logic [3:0] code, output logic has, output wfd_pkg::res_t r);
    r = '0;
    r.kind = wfd_pkg::KIND_ERROR;
    r.error_code = code;
    ph = P_HALT;
    has = 1;
  endtask

  task automatic parse_byte(logic [7:0] b, output logic has, output wfd_pkg::res_t r);
    logic [31:0] v;
    logic [63:0] nf, bps;
    has = 0;
    r = '0;
    bps = 64'((bits >> 3) & 7);
    case (ph)
      P_RIFF: if (gather(b, 4)) begin
        v = gshift; gshift = 0;
        if (v != wfd_pkg::ID_RIFF) flag_error(wfd_pkg::ERR_NOT_RIFF, has, r);
        else ph = P_RSIZE;
      end
      P_RSIZE: if (gather(b, 4)) begin
        gshift = 0; ph = P_WAVE;
      end
      P_WAVE: if (gather(b, 4)) begin
        v = gshift; gshift = 0;
        if (v != wfd_pkg::ID_WAVE) flag_error(wfd_pkg::ERR_NOT_WAVE, has, r);
        else ph = P_CID;
      end
      P_CID: if (gather(b, 4)) begin
        ckid = gshift; gshift = 0; ph = P_CSIZE;
      end
      P_CSIZE: if (gather(b, 4)) begin
        v = gshift; gshift = 0;
        if (ckid == wfd_pkg::ID_FMT) begin
          if (v < 16) flag_error(wfd_pkg::ERR_SHORT_FMT, has, r);
          else begin
            skip_left = 64'(v - 16) + 64'(v[0]);
            ph = P_TAG;
          end
        end else if (ckid == wfd_pkg::ID_DATA) begin
          if (!fmt_ok) flag_error(wfd_pkg::ERR_DATA_FIRST, has, r);
          else begin
            nf = 64'(v) / (64'(chans) * bps);
            r.kind = wfd_pkg::KIND_HEADER;
            r.channel_count = chans;
            r.sample_rate = rate;
            r.sample_bits = bits[5:0];
            r.float_source = (tag_seen == wfd_pkg::TAG_FLT);
            r.total_frames = nf[31:0];
            r.length_ms = 42'((nf * 1000) / 64'(rate));
            has = 1;
            data_left = v; frames = 0; chan_idx = 0;
            ph = (v == 0) ? P_DONE : P_DATA;
          end
        end else begin
          skip_left = 64'(v) + 64'(v[0]);
          ph = (skip_left == 0) ? P_CID : P_SKIP;
        end
      end
      P_TAG: if (gather(b, 2)) begin
        tag_seen = gshift[15:0]; gshift = 0;
        if (tag_seen == wfd_pkg::TAG_MP3) flag_error(wfd_pkg::ERR_MP3, has, r);
        else if (tag_seen != wfd_pkg::TAG_PCM && tag_seen != wfd_pkg::TAG_FLT)
          flag_error(wfd_pkg::ERR_TAG, has, r);
        else ph = P_CHAN;
      end
      P_CHAN: if (gather(b, 2)) begin
        chans = gshift[15:0]; gshift = 0; ph = P_RATE;
      end
      P_RATE: if (gather(b, 4)) begin
        rate = gshift; gshift = 0; ph = P_GAP;
      end
      P_GAP: begin
        gcnt++;
        if (gcnt >= 6) begin
          gcnt = 0; ph = P_BITS;
        end
      end
      P_BITS: if (gather(b, 2)) begin
        bits = gshift[15:0]; gshift = 0;
        if (tag_seen == wfd_pkg::TAG_FLT ? bits != 32 : (bits != 8 && bits != 16 && bits != 24))
          flag_error(wfd_pkg::ERR_DEPTH, has, r);
        else if (chans == 0 || rate == 0) flag_error(wfd_pkg::ERR_ZERO, has, r);
        else begin
          fmt_ok = 1;
          ph = (skip_left == 0) ? P_CID : P_SKIP;
        end
      end
      P_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) ph = P_CID;
      end
      P_DATA: begin
        has = gather(b, int'(bps));
        data_left--;
        if (data_left == 0) ph = P_DONE;
        if (has) begin
          v = gshift; gshift = 0;
          chan_idx++;
          if (chan_idx >= chans) begin
            chan_idx = 0; frames++;
          end
          r.kind = wfd_pkg::KIND_SAMPLE;
          r.sample = to_pcm16(v);
          r.frame_position = frames;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_item(logic [7:0] b, logic last);
    logic          has;
    wfd_pkg::res_t r;
    parse_e        was;
    was = ph;
    parse_byte(b, has, r);
    if (last) begin
      if (!has && ph != P_HALT && was < P_DATA) begin
        if (was == P_RIFF) flag_error(wfd_pkg::ERR_NOT_RIFF, has, r);
        else if (was == P_RSIZE || was == P_WAVE) flag_error(wfd_pkg::ERR_NOT_WAVE, has, r);
        else flag_error(wfd_pkg::ERR_NO_DATA, has, r);
      end
      clear_parser();
    end
    if (has) decoded_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  task automatic check_result();
    wfd_pkg::res_t e;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected item kind %0d tdata %0h", $time, m_tuser, m_tdata);
      mismatches++;
      return;
    end
    e = decoded_q.pop_front();
    case (e.kind)
      wfd_pkg::KIND_SAMPLE: n_samples++;
      wfd_pkg::KIND_HEADER: n_headers++;
      default:              n_errors++;
    endcase
    check_field("kind", 64'(e.kind), 64'(m_tuser));
    check_field("sample", 64'(e.sample), 64'(m_tdata[15:0]));
    check_field("frame_position", 64'(e.frame_position), 64'(m_tdata[47:16]));
    check_field("channel_count", 64'(e.channel_count), 64'(m_tdata[63:48]));
    check_field("sample_rate", 64'(e.sample_rate), 64'(m_tdata[95:64]));
    check_field("sample_bits", 64'(e.sample_bits), 64'(m_tdata[101:96]));
    check_field("float_source", 64'(e.float_source), 64'(m_tdata[102]));
    check_field("total_frames", 64'(e.total_frames), 64'(m_tdata[134:103]));
    check_field("length_ms", 64'(e.length_ms), 64'(m_tdata[176:135]));
    check_field("error_code", 64'(e.error_code), 64'(m_tdata[180:177]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_item(s_tdata, s_tlast);
        n_bytes++;
      end
      if (m_tvalid && m_tready) check_result();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= 4000) begin
        $display("%0t: no progress, %0d items still expected", $time, decoded_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    byte_item_t it;
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || in_fire) begin
      if (file_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        it = file_bytes.pop_front();
        s_tdata <= it.b;
        s_tlast <= it.last;
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
    m_tready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  logic [7:0] cur[$];

  task automatic put16(logic [15:0] v);
    cur.push_back(v[7:0]); cur.push_back(v[15:8]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[15:0]); put16(v[31:16]);
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: case ($urandom_range(0, 9))
        0: return 32'h3f80_0000;
        1: return 32'hbf80_0000;
        2: return 32'h7fc0_0001;
        3: return 32'h7f80_0000;
        4: return 32'hff80_0000;
        5: return 32'h3f7f_ffff;
        6: return 32'h0000_0001;
        7: return 32'h8000_0000;
        8: return 32'hc700_0000;
        default: return 32'hffff_ffff;
      endcase
      default: return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
    endcase
  endfunction

  task automatic junk_chunk();
    logic [31:0] id, sz;
    id = $urandom;
    if (id == wfd_pkg::ID_FMT || id == wfd_pkg::ID_DATA) id = 32'h5453_494c;
    sz = $urandom_range(0, 5);
    put32(id); put32(sz);
    repeat (sz + sz[0]) cur.push_back(8'($urandom));
  endtask

  task automatic fmt_chunk(logic [15:0] tag, logic [15:0] ch, logic [31:0] rt,
                           logic [15:0] bt, logic [31:0] fsz);
    put32(wfd_pkg::ID_FMT); put32(fsz);
    put16(tag); put16(ch); put32(rt);
    repeat (6) cur.push_back(8'($urandom));
    put16(bt);
    if (fsz > 16) repeat (fsz - 16 + fsz[0]) cur.push_back(8'($urandom));
  endtask

  task automatic build_file(file_e mode);
    logic [15:0] tag, bt, ch;
    logic [31:0] rt, fsz, dsz, w;
    int          dlen, cut, n;
    byte_item_t  it;
    cur.delete();
    tag = $urandom_range(0, 1) ? wfd_pkg::TAG_FLT : wfd_pkg::TAG_PCM;
    case ($urandom_range(0, 2))
      0: bt = 16'd8;
      1: bt = 16'd16;
      default: bt = 16'd24;
    endcase
    if (tag == wfd_pkg::TAG_FLT) bt = 16'd32;
    ch = 16'($urandom_range(1, 3));
    case ($urandom_range(0, 5))
      0: rt = 32'd1;
      1: rt = 32'hffff_ffff;
      2: rt = $urandom;
      default: rt = $urandom_range(8000, 48000);
    endcase
    fsz = ($urandom_range(0, 3) == 0) ? 16 + $urandom_range(1, 5) : 16;
    dsz = $urandom_range(0, 40);
    dlen = dsz + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0);
    case (mode)
      F_MP3:       tag = wfd_pkg::TAG_MP3;
      F_BAD_TAG:   tag = ($urandom_range(0, 1)) ? 16'hffff : 16'h0002 + 16'($urandom_range(2, 80));
      F_BAD_DEPTH: bt = ($urandom_range(0, 1)) ? 16'hffff : 16'($urandom_range(0, 40));
      F_ZERO_CH:   ch = 16'd0;
      F_ZERO_RATE: rt = 32'd0;
      F_SHORT_FMT: fsz = $urandom_range(0, 15);
      F_HUGE: begin
        dsz = 32'hffff_ffff; dlen = $urandom_range(4, 30);
      end
      F_WIDE: begin
        ch = 16'hffff; rt = 32'hffff_ffff;
      end
      default: ;
    endcase
    if (mode == F_BAD_TAG && (tag == wfd_pkg::TAG_PCM || tag == wfd_pkg::TAG_FLT ||
                              tag == wfd_pkg::TAG_MP3))
      tag = 16'h0002;
    put32(mode == F_NOT_RIFF ? 32'h4646_4953 ^ 32'($urandom_range(0, 255)) : wfd_pkg::ID_RIFF);
    put32($urandom);
    put32(mode == F_NOT_WAVE ? wfd_pkg::ID_WAVE ^ (32'd1 << $urandom_range(0, 31)) :
                               wfd_pkg::ID_WAVE);
    if (mode == F_DATA_FIRST) begin
      put32(wfd_pkg::ID_DATA); put32(32'd4); put32($urandom);
    end
    repeat ($urandom_range(0, 2)) junk_chunk();
    if (mode == F_TWO_FMT) fmt_chunk(wfd_pkg::TAG_PCM, 16'd2, 32'd22050, 16'd8, 32'd16);
    fmt_chunk(tag, ch, rt, bt, fsz);
    if (mode == F_NO_DATA) begin
      junk_chunk();
    end else begin
      put32(wfd_pkg::ID_DATA); put32(dsz);
      n = 0;
      while (n < dlen) begin
        w = (tag == wfd_pkg::TAG_FLT) ? pick_float() : $urandom;
        for (int i = 0; i < 4 && n < dlen; i++) begin
          cur.push_back(w[8*i +: 8]);
          n++;
        end
      end
    end
    if (mode == F_TRUNC) begin
      cut = $urandom_range(1, cur.size());
      while (cur.size() > cut) void'(cur.pop_back());
    end
    if (mode == F_CORRUPT) cur[$urandom_range(0, 43)] = 8'($urandom);
    if (mode == F_NOISE) begin
      cur.delete();
      repeat ($urandom_range(1, 20)) cur.push_back(8'($urandom));
    end
    foreach (cur[i]) begin
      it.b = cur[i];
      it.last = (i == cur.size() - 1);
      file_bytes.push_back(it);
    end
  endtask

  task automatic drain();
    while (file_bytes.size() != 0 || s_tvalid || decoded_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  initial begin
    file_e m;
    int    budget;
    clear_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      budget = 300;
      for (int i = int'(F_GOOD) + p; i <= int'(F_WIDE); i += 4) build_file(file_e'(i));
      while (file_bytes.size() < budget) begin
        case ($urandom_range(0, 19))
          0, 1:  m = F_TRUNC;
          2:     m = F_CORRUPT;
          3:     m = F_NOISE;
          4:     m = file_e'($urandom_range(int'(F_NOT_RIFF), int'(F_WIDE)));
          default: m = F_GOOD;
        endcase
        build_file(m);
      end
      drain();
    end
    $display("%0d file bytes sent under four idle/stall mixes", n_bytes);
    $display("%0d samples, %0d headers, %0d errors checked", n_samples, n_headers, n_errors);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
